### hdl/pfla_pkg.sv
package pfla_pkg;

   // result field widths
   localparam int ADDR_W  = 32;
   localparam int COUNT_W = 17;

   // lowest byte address that may be freed (1 MiB)
   localparam logic [ADDR_W-1:0] LOW_LIMIT = 32'h0010_0000;

   // reset value of the phys_top register
   localparam logic [ADDR_W-1:0] PHYS_TOP_RESET = 32'h0E00_0000;

   // request operation codes
   typedef enum logic {
      OP_FREE  = 1'b0,
      OP_ALLOC = 1'b1
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_ADDR = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // engine sequencer states
   typedef enum logic [1:0] {
      ENG_IDLE = 2'd0,
      ENG_READ = 2'd1,
      ENG_DONE = 2'd2
   } eng_state_type;

   // one result item
   typedef struct packed {
      logic [ADDR_W-1:0]  granted_address;
      status_type         status;
      logic [COUNT_W-1:0] free_count;
   } result_type;

endpackage

### hdl/page_free_list_allocator.sv
// a free item passes the engine's IDLE and DONE states and then the output register before rsp_valid
// rises; an allocate also passes the READ state, for the registered read of the free-page memory
// the engine takes no new request until it has handed the last result to the output register,
// so rsp_stall can hold the request channel
// reset: synchronous, clears the stack pointer (empty list) and loads phys_top with 0x0E000000;
// memory contents are not cleared, so no clearing pass is needed
module page_free_list_allocator
   import pfla_pkg::*;
#(
   parameter int STACK_DEPTH = 65536,
   parameter int PAGE_BYTES  = 4096
) (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_wr_en,
   input  logic [ADDR_W-1:0]  csr_wr_data,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [ADDR_W-1:0]  req_page_address,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ADDR_W-1:0]  rsp_granted_address,
   output logic [1:0]         rsp_status,
   output logic [COUNT_W-1:0] rsp_free_count
);

   // phys_top register, exclusive upper bound for freed addresses
   logic [ADDR_W-1:0] csr_phys_top_ff;

   // handoff between engine and output register
   logic       res_valid;
   logic       res_take;
   result_type res_data;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_phys_top_ff <= PHYS_TOP_RESET;
      end else if (csr_wr_en) begin
         csr_phys_top_ff <= csr_wr_data;
      end
   end

   // engine: address check, stack pointer and free-page memory
   pfla_engine #(
      .STACK_DEPTH(STACK_DEPTH),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_page_address(req_page_address),
      .phys_top        (csr_phys_top_ff),
      .res_valid       (res_valid),
      .res_data        (res_data),
      .res_take        (res_take)
   );

   // the output register takes a new item when empty or being drained this cycle,
   // so the engine can finish the next item while a result still waits
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds while stalled
   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= res_data;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_ff.granted_address;
   assign rsp_status          = rsp_ff.status;
   assign rsp_free_count      = rsp_ff.free_count;

endmodule

### hdl/pfla_ram.sv
module pfla_ram
   import pfla_pkg::*;
#(
   parameter int DEPTH = 65536,
   parameter int WIDTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/pfla_engine.sv
module pfla_engine
   import pfla_pkg::*;
#(
   parameter int STACK_DEPTH = 65536,
   parameter int PAGE_BYTES  = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_operation,
   input  logic [ADDR_W-1:0] req_page_address,
   input  logic [ADDR_W-1:0] phys_top,
   output logic              res_valid,
   output result_type        res_data,
   input  logic              res_take
);

   localparam int OW = $clog2(PAGE_BYTES);
   localparam int PW = ADDR_W - OW;
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int TW = $clog2(STACK_DEPTH + 1);
   localparam logic [TW-1:0] FULL_COUNT = TW'(STACK_DEPTH);

   eng_state_type state_ff, state_in;
   logic [TW-1:0] top_ff, top_in;
   result_type    res_ff, res_in;

   logic          accept;
   logic          bad_addr;
   logic          wr_en;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [PW-1:0] rd_data;

   pfla_ram #(
      .DEPTH(STACK_DEPTH),
      .WIDTH(PW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(top_ff[AW-1:0]),
      .wr_data(req_page_address[ADDR_W-1:OW]),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign accept   = req_valid && !req_stall;
   assign bad_addr = (req_page_address[OW-1:0] != '0)
                     || (req_page_address < LOW_LIMIT)
                     || (req_page_address >= phys_top);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         top_ff   <= '0;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   always_comb begin
      state_in  = state_ff;
      top_in    = top_ff;
      res_in    = res_ff;
      req_stall = 1'b1;
      res_valid = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = AW'(top_ff - 1'b1);
      case (state_ff)
         ENG_IDLE: begin
            req_stall = 1'b0;
            if (accept) begin
               res_in.granted_address = '0;
               res_in.status          = ST_OK;
               state_in               = ENG_DONE;
               if (req_operation == OP_FREE) begin
                  if (bad_addr) begin
                     res_in.status = ST_BAD_ADDR;
                  end else if (top_ff >= FULL_COUNT) begin
                     res_in.status = ST_FULL;
                  end else begin
                     wr_en  = 1'b1;
                     top_in = top_ff + 1'b1;
                  end
               end else begin
                  if (top_ff == '0) begin
                     res_in.status = ST_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     top_in   = top_ff - 1'b1;
                     state_in = ENG_READ;
                  end
               end
               res_in.free_count = COUNT_W'(top_in);
            end
         end
         ENG_READ: begin
            res_in.granted_address = {rd_data, {OW{1'b0}}};
            state_in               = ENG_DONE;
         end
         ENG_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = ENG_IDLE;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   assign res_data = res_ff;

   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= FULL_COUNT)
      else $error("stack pointer beyond depth");

   a_read_after_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == ENG_READ |-> $past(accept) && $past(req_operation) == OP_ALLOC)
      else $error("memory read state without a pop");

   a_pop_decrements: assert property (@(posedge clock) disable iff (reset)
      accept && req_operation == OP_ALLOC && top_ff != '0
      |=> top_ff == $past(top_ff) - 1'b1)
      else $error("pop did not move the pointer down");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      state_ff == ENG_DONE |-> res_ff.free_count == COUNT_W'(top_ff))
      else $error("reported free count differs from pointer");

endmodule

### verif/pfla_checker.sv
module pfla_checker
   import pfla_pkg::*;
#(
   parameter int STACK_DEPTH = 65536,
   parameter int PAGE_BYTES  = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [ADDR_W-1:0]  csr_wr_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_operation,
   input  logic [ADDR_W-1:0]  req_page_address,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [ADDR_W-1:0]  rsp_granted_address,
   input  logic [1:0]         rsp_status,
   input  logic [COUNT_W-1:0] rsp_free_count,
   output int unsigned        error_count,
   output int unsigned        pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   // shadow of the free page stack, holding page numbers
   logic [ADDR_W-1:0] free_pages [STACK_DEPTH];
   int unsigned       free_depth;
   logic [ADDR_W-1:0] phys_top_shadow;
   result_type        awaited_results[$];
   result_type        oldest;
   int unsigned       mismatches = 0;

   initial pending_count = 0;
   assign error_count = mismatches;

   // one free or allocate against the shadow stack
   function automatic result_type free_or_allocate(op_type op, logic [ADDR_W-1:0] addr);
      result_type r;
      r.granted_address = '0;
      r.status          = ST_OK;
      if (op == OP_FREE) begin
         if ((addr % PAGE_BYTES) != 0 || addr < LOW_LIMIT || addr >= phys_top_shadow) begin
            r.status = ST_BAD_ADDR;
         end else if (free_depth >= STACK_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            free_pages[free_depth] = addr / PAGE_BYTES;
            free_depth++;
         end
      end else begin
         if (free_depth == 0) begin
            r.status = ST_EMPTY;
         end else begin
            free_depth--;
            r.granted_address = free_pages[free_depth] * PAGE_BYTES;
         end
      end
      r.free_count = free_depth[COUNT_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                  logic [ADDR_W-1:0] want);
      $display("[%0t] mismatch, %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         free_depth      = 0;
         phys_top_shadow = PHYS_TOP_RESET;
         awaited_results.delete();
      end else begin
         if (csr_wr_en) begin
            phys_top_shadow = csr_wr_data;
         end
         // results first: a result never belongs to an item taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result with nothing awaited", rsp_granted_address, '0);
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_granted_address !== oldest.granted_address)
                  report_mismatch("granted_address", rsp_granted_address,
                                  oldest.granted_address);
               if (rsp_status !== oldest.status)
                  report_mismatch("status", ADDR_W'(rsp_status), ADDR_W'(oldest.status));
               if (rsp_free_count !== oldest.free_count)
                  report_mismatch("free_count", ADDR_W'(rsp_free_count),
                                  ADDR_W'(oldest.free_count));
            end
         end
         if (req_valid && !req_stall) begin
            awaited_results.push_back(free_or_allocate(op_type'(req_operation),
                                                       req_page_address));
         end
      end
      pending_count <= awaited_results.size();
   end

endmodule

### verif/tb_top.sv
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import pfla_pkg::*;

   localparam int          STACK_DEPTH = 65536;
   localparam int          PAGE_BYTES  = 4096;
   // watchdog limit, above the worst correct run with every gap and stall at 17
   localparam int unsigned CYCLE_LIMIT = 300_000;
   localparam int unsigned RANDOM_ITEMS = 560;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [ADDR_W-1:0]  csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_operation = 1'b0;
   logic [ADDR_W-1:0]  req_page_address = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [ADDR_W-1:0]  rsp_granted_address;
   logic [1:0]         rsp_status;
   logic [COUNT_W-1:0] rsp_free_count;

   int unsigned error_count;
   int unsigned pending_count;

   // idling switches for sender and receiver, drawn anew per burst
   bit tx_idle = 1'b1;
   bit rx_idle = 1'b1;

   int unsigned       rx_hold = 0;
   int unsigned       rx_hold_next;
   int unsigned       cycles = 0;
   int unsigned       frees_sent = 0;
   int unsigned       allocs_sent = 0;
   int unsigned       phys_top_writes = 0;
   int unsigned       random_sent = 0;
   int unsigned       burst_len;
   logic [ADDR_W-1:0] phys_top_now = PHYS_TOP_RESET;

   always #1 clock = ~clock;

   page_free_list_allocator #(
      .STACK_DEPTH (STACK_DEPTH),
      .PAGE_BYTES  (PAGE_BYTES)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_page_address    (req_page_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status),
      .rsp_free_count      (rsp_free_count)
   );

   pfla_checker #(
      .STACK_DEPTH (STACK_DEPTH),
      .PAGE_BYTES  (PAGE_BYTES)
   ) result_check (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_page_address    (req_page_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status),
      .rsp_free_count      (rsp_free_count),
      .error_count         (error_count),
      .pending_count       (pending_count)
   );

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still awaited", cycles, pending_count);
         $display("page_free_list_allocator verification failed");
         $finish;
      end
   end

   // receiver: after each taken result, hold stall for a drawn number of cycles
   // (the hold runs whether or not a result is waiting, so it lands on every phase)
   always @(posedge clock) begin
      if (reset) begin
         rx_hold   <= 0;
         rsp_stall <= 1'b0;
      end else begin
         rx_hold_next = rx_hold;
         if (rsp_valid && !rsp_stall) begin
            rx_hold_next = rx_idle ? $urandom_range(17, 0) : 0;
         end else if (rx_hold_next != 0) begin
            rx_hold_next--;
         end
         rx_hold   <= rx_hold_next;
         rsp_stall <= (rx_hold_next != 0);
      end
   end

   // one item on the request channel; valid stays up between back-to-back items
   task automatic send_item(op_type op, logic [ADDR_W-1:0] addr);
      int unsigned gap;
      gap = tx_idle ? $urandom_range(17, 0) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_page_address <= addr;
      do @(posedge clock); while (req_stall);
      if (op == OP_FREE) frees_sent++;
      else allocs_sent++;
   endtask

   // drop valid and wait for every awaited result (the count is registered, so it lags the queue)
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // phys_top only changes with the block idle
   task automatic set_phys_top(logic [ADDR_W-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      phys_top_now = value;
      phys_top_writes++;
   endtask

   // mostly legal pages under the current top, plus misaligned, edge and junk addresses
   function automatic logic [ADDR_W-1:0] pick_free_address();
      int unsigned       pick;
      logic [ADDR_W-1:0] page;
      logic [ADDR_W-1:0] top_page;
      pick     = $urandom_range(9, 0);
      top_page = (phys_top_now - 1) / PAGE_BYTES;
      if (phys_top_now > LOW_LIMIT)
         page = $urandom_range(top_page, LOW_LIMIT / PAGE_BYTES);
      else
         page = $urandom_range(LOW_LIMIT / PAGE_BYTES, 0);
      case (pick)
         7: begin
            return page * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1, 1);
         end
         8: begin
            return $urandom();
         end
         9: begin
            case ($urandom_range(3, 0))
               0: return phys_top_now & ~(PAGE_BYTES - 1);
               1: return (phys_top_now & ~(PAGE_BYTES - 1)) - PAGE_BYTES;
               2: return LOW_LIMIT - PAGE_BYTES;
               default: return LOW_LIMIT;
            endcase
         end
         default: begin
            return page * PAGE_BYTES;
         end
      endcase
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pop, address check edges, double free, pop to empty
      send_item(OP_ALLOC, 32'h0000_0000);
      send_item(OP_FREE, 32'h0000_0000);
      send_item(OP_FREE, LOW_LIMIT - PAGE_BYTES);
      send_item(OP_FREE, LOW_LIMIT);
      send_item(OP_FREE, LOW_LIMIT + 1);
      send_item(OP_FREE, LOW_LIMIT + PAGE_BYTES / 2);
      send_item(OP_FREE, PHYS_TOP_RESET - PAGE_BYTES);
      send_item(OP_FREE, PHYS_TOP_RESET);
      send_item(OP_FREE, 32'hFFFF_FFFF);
      send_item(OP_FREE, 32'h0020_0000);
      send_item(OP_FREE, 32'h0020_0000);
      repeat (5) send_item(OP_ALLOC, $urandom());

      // top at the maximum: highest page frees and comes back out
      // (this also holds the sender until all results are in)
      set_phys_top(32'hFFFF_FFFF);
      send_item(OP_FREE, 32'hFFFF_F000);
      send_item(OP_FREE, 32'hFFFF_FFFF);
      send_item(OP_ALLOC, 32'hFFFF_FFFF);

      // top of zero and top at 1 MiB reject everything
      set_phys_top(32'h0000_0000);
      send_item(OP_FREE, LOW_LIMIT);
      set_phys_top(LOW_LIMIT);
      send_item(OP_FREE, LOW_LIMIT);

      // one legal page only
      set_phys_top(LOW_LIMIT + PAGE_BYTES);
      send_item(OP_FREE, LOW_LIMIT);
      send_item(OP_FREE, LOW_LIMIT + PAGE_BYTES);
      send_item(OP_ALLOC, 32'h0000_0000);

      // random bursts, each with its own idling mix and sometimes a new top
      while (random_sent < RANDOM_ITEMS) begin
         burst_len = $urandom_range(60, 10);
         tx_idle   = ($urandom_range(3, 0) != 0);
         rx_idle   = ($urandom_range(3, 0) != 0);
         if ($urandom_range(1, 0) != 0) begin
            case ($urandom_range(4, 0))
               0: set_phys_top(PHYS_TOP_RESET);
               1: set_phys_top(32'hFFFF_FFFF);
               2: set_phys_top($urandom());
               3: set_phys_top(LOW_LIMIT + PAGE_BYTES * $urandom_range(64, 1));
               default: set_phys_top($urandom_range(LOW_LIMIT, 0));
            endcase
         end
         repeat (burst_len) begin
            if ($urandom_range(99, 0) < 45)
               send_item(OP_ALLOC, $urandom());
            else
               send_item(OP_FREE, pick_free_address());
            random_sent++;
         end
      end

      // wind down: all results in, then a quiet wait for strays
      drain_results();
      repeat (10) @(posedge clock);

      $display("covered %0d frees and %0d allocates over %0d phys_top settings,",
               frees_sent, allocs_sent, phys_top_writes);
      $display("address check edges, empty pops, %0d random items in bursts, %0d cycles",
               random_sent, cycles);
      if (error_count == 0) begin
         $display("page_free_list_allocator verification clean");
      end else begin
         $display("page_free_list_allocator verification failed");
      end
      $finish;
   end

endmodule
